[rtl/compacting_value_list_top_defines.svh]
// Assertion macros for the checker file of the compacting value list.
// No dependencies; every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef COMPACTING_VALUE_LIST_TOP_DEFINES_SVH
`define COMPACTING_VALUE_LIST_TOP_DEFINES_SVH

// Concurrent assertion with a fixed failure message.
`define CVL_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("compacting value list check failed");

// Concurrent assertion with a caller supplied failure message.
`define CVL_ASSERT_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

`endif

[rtl/cvl_pkg.sv]
// Package of the compacting value list: port widths, default parameters,
// opcode and status codes, and the per-cell command struct. No dependencies.
package cvl_pkg;

  localparam int CAPACITY_DEF    = 256;
  localparam int VALUE_WIDTH_DEF = 32;

  localparam int OPCODE_W = 3;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 8;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 9;

  typedef enum logic [OPCODE_W-1:0] {
    OP_APPEND     = 3'd0,
    OP_REMOVE_VAL = 3'd1,
    OP_REMOVE_IDX = 3'd2,
    OP_FIND_VAL   = 3'd3,
    OP_READ_IDX   = 3'd4
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_MISSING = 2'd2,
    ST_RANGE   = 2'd3
  } status_e;

  typedef struct packed {
    logic capture;
    logic load;
    logic shift;
  } cell_cmd_t;

endpackage

[rtl/cvl_cell.sv]
// One storage cell of the compacting value list: holds one entry and a match flag.
// Depends on cvl_pkg for the command struct.
module cvl_cell #(
  parameter int VW = cvl_pkg::VALUE_WIDTH_DEF
) (
  input  logic              clk_i,
  input  cvl_pkg::cell_cmd_t cmd_i,
  input  logic [VW-1:0]     probe_i,
  input  logic [VW-1:0]     load_i,
  input  logic [VW-1:0]     next_i,
  output logic [VW-1:0]     entry_o,
  output logic              match_o
);
  import cvl_pkg::*;

  logic [VW-1:0] entry_q;
  logic          match_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      entry_q <= load_i;
    end else if (cmd_i.shift) begin
      entry_q <= next_i;
    end
    if (cmd_i.capture) begin
      match_q <= (entry_q == probe_i);
    end
  end

  assign entry_o = entry_q;
  assign match_o = match_q;

endmodule

[rtl/compacting_value_list_top.sv]
// Top level of the compacting value list: a row of cvl_cell entries plus control.
// Depends on cvl_pkg and cvl_cell.
//
// Usage: the input channel (in_valid_i/in_ready_o) carries one beat per
// operation: opcode_i, value_i and position_i. The output channel
// (out_valid_o/out_ready_i) returns exactly one result beat per input beat:
// status_o, value_out_o, position_out_o and count_out_o.
// Each operation runs as follows: in the accept cycle (S_IDLE) every cell compares
// its entry with the incoming value; in the S_EXEC state, which holds while the
// output register still has an untaken result, the first match or the addressed
// position is selected, the result is registered and the row shifts down by one
// place from the removed entry onward. No new beat is accepted until then.
// A finished result waits in the output register while the next beat is
// accepted; if that result is still not taken, the second operation holds
// in its execute cycle until the output register frees up.
// Reset clears the count and the handshake state; entry contents are not
// cleared, and only positions below the count are ever read.
module compacting_value_list_top #(
  parameter int CAPACITY    = cvl_pkg::CAPACITY_DEF,
  parameter int VALUE_WIDTH = cvl_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [cvl_pkg::OPCODE_W-1:0]         opcode_i,
  input  logic signed [cvl_pkg::VALUE_W-1:0]   value_i,
  input  logic [cvl_pkg::POS_W-1:0]            position_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [cvl_pkg::STATUS_W-1:0]         status_o,
  output logic signed [cvl_pkg::VALUE_W-1:0]   value_out_o,
  output logic [cvl_pkg::POS_W-1:0]            position_out_o,
  output logic [cvl_pkg::COUNT_W-1:0]          count_out_o
);
  import cvl_pkg::*;

  localparam int VW = VALUE_WIDTH;
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > POS_W) ? CW : POS_W;
  localparam int YW = (CW > COUNT_W) ? CW : COUNT_W;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e         state_q;
  logic [CW-1:0]  count_q;
  logic           out_valid_q;
  status_e        status_q;
  logic [VALUE_W-1:0] vout_q;
  logic [POS_W-1:0]   pout_q;
  logic [COUNT_W-1:0] cnt_out_q;

  op_e            op_q;
  logic [VW-1:0]  val_q;
  logic [POS_W-1:0] pos_q;

  logic           in_fire;
  logic           exec_fire;
  logic signed [63:0] in_ext;
  logic [VW-1:0]  probe;

  logic [VW-1:0]       entry [CAPACITY];
  logic [CAPACITY-1:0] match;
  logic [CAPACITY-1:0] valid;
  logic [CAPACITY-1:0] match_v;
  logic [CAPACITY-1:0] pre;
  logic [CAPACITY-1:0] first;
  logic [CAPACITY-1:0] idx_hot;
  logic [CAPACITY-1:0] ge_pos;
  logic [CAPACITY-1:0] sel;
  logic [CAPACITY-1:0] mask;
  cell_cmd_t           cmd [CAPACITY];

  logic [XW-1:0]  count_x;
  logic [XW-1:0]  pos_x;
  logic           is_value_op;
  logic           is_remove;
  logic           full;
  logic           hit;
  logic [VW-1:0]  rd;
  logic [IW-1:0]  po_enc;

  status_e        status_d;
  logic [CW-1:0]  count_d;
  logic [XW-1:0]  po_d;
  logic           vo_en;
  logic signed [VW-1:0] res_s;
  logic signed [63:0]   res_x;
  logic [YW-1:0]  count_y;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i & in_ready_o;
  assign exec_fire  = (state_q == S_EXEC) & (~out_valid_q | out_ready_i);

  assign in_ext = 64'(value_i);
  assign probe  = in_ext[VW-1:0];

  assign count_x = XW'(count_q);
  assign pos_x   = XW'(pos_q);

  assign is_value_op = (op_q == OP_REMOVE_VAL) || (op_q == OP_FIND_VAL);
  assign is_remove   = (op_q == OP_REMOVE_VAL) || (op_q == OP_REMOVE_IDX);
  assign full        = (count_q == CAP_C);

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [VW-1:0] next_val;

    assign valid[g]   = (XW'(g) < count_x);
    assign idx_hot[g] = (XW'(g) == pos_x) & valid[g];
    assign ge_pos[g]  = (XW'(g) >= pos_x);

    if (g == CAPACITY - 1) begin : g_last
      assign next_val = entry[g];
    end else begin : g_mid
      assign next_val = entry[g+1];
    end

    assign cmd[g].capture = in_fire;
    assign cmd[g].load    = exec_fire & (op_q == OP_APPEND) & ~full & (XW'(g) == count_x);
    assign cmd[g].shift   = exec_fire & is_remove & hit & mask[g];

    cvl_cell #(
      .VW(VW)
    ) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd[g]),
      .probe_i (probe),
      .load_i  (val_q),
      .next_i  (next_val),
      .entry_o (entry[g]),
      .match_o (match[g])
    );
  end

  assign match_v = match & valid;

  always_comb begin
    pre = match_v;
    for (int k = 1; k < CAPACITY; k = k * 2) begin
      pre = pre | (pre << k);
    end
  end

  assign first = match_v & ~(pre << 1);
  assign sel   = is_value_op ? first : idx_hot;
  assign mask  = is_value_op ? pre : ge_pos;
  assign hit   = |sel;

  always_comb begin
    rd     = '0;
    po_enc = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (sel[i]) begin
        rd     = rd | entry[i];
        po_enc = po_enc | IW'(i);
      end
    end
  end

  always_comb begin
    status_d = ST_OK;
    count_d  = count_q;
    po_d     = '0;
    vo_en    = 1'b0;
    res_s    = rd;
    case (op_q)
      OP_APPEND: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          po_d    = count_x;
          vo_en   = 1'b1;
          res_s   = val_q;
          count_d = count_q + CW'(1);
        end
      end
      OP_REMOVE_VAL, OP_FIND_VAL: begin
        if (hit) begin
          po_d  = XW'(po_enc);
          vo_en = 1'b1;
          if (op_q == OP_REMOVE_VAL) begin
            count_d = count_q - CW'(1);
          end
        end else begin
          status_d = ST_MISSING;
        end
      end
      OP_REMOVE_IDX, OP_READ_IDX: begin
        if (hit) begin
          po_d  = pos_x;
          vo_en = 1'b1;
          if (op_q == OP_REMOVE_IDX) begin
            count_d = count_q - CW'(1);
          end
        end else begin
          status_d = ST_RANGE;
        end
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
  end

  assign res_x   = 64'(res_s);
  assign count_y = YW'(count_d);

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q  <= op_e'(opcode_i);
      val_q <= probe;
      pos_q <= position_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      status_q    <= ST_OK;
      vout_q      <= '0;
      pout_q      <= '0;
      cnt_out_q   <= '0;
    end else begin
      if (exec_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (exec_fire) begin
            state_q     <= S_IDLE;
            count_q     <= count_d;
            status_q    <= status_d;
            vout_q      <= vo_en ? res_x[VALUE_W-1:0] : '0;
            pout_q      <= po_d[POS_W-1:0];
            cnt_out_q   <= count_y[COUNT_W-1:0];
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign value_out_o    = vout_q;
  assign position_out_o = pout_q;
  assign count_out_o    = cnt_out_q;

endmodule

[rtl/cvl_checker.sv]
// Port-level checker for compacting_value_list_top, attached by the bind below.
// Depends on cvl_pkg and the macros in compacting_value_list_top_defines.svh.
`include "compacting_value_list_top_defines.svh"

module cvl_checker #(
  parameter int CAPACITY = cvl_pkg::CAPACITY_DEF
) (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_ready_o,
  input logic                               out_valid_o,
  input logic                               out_ready_i,
  input logic [cvl_pkg::STATUS_W-1:0]       status_o,
  input logic signed [cvl_pkg::VALUE_W-1:0] value_out_o,
  input logic [cvl_pkg::POS_W-1:0]          position_out_o,
  input logic [cvl_pkg::COUNT_W-1:0]        count_out_o
);
  import cvl_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int YW = (CW > COUNT_W) ? CW : COUNT_W;
  localparam logic [YW-1:0] CAP_Y = YW'(CAPACITY);
  localparam logic [COUNT_W-1:0] CAP_OUT = CAP_Y[COUNT_W-1:0];

  `CVL_ASSERT_MSG(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o,
    "Result beat dropped before it was taken.")
  `CVL_ASSERT_MSG(a_one_in_flight, in_valid_i && in_ready_o |=> !in_ready_o,
    "A second beat was accepted while one is still executing.")
  `CVL_ASSERT(a_fail_zero, out_valid_o && (status_o != ST_OK) |->
    (value_out_o == '0) && (position_out_o == '0))
  `CVL_ASSERT(a_full_count, out_valid_o && (status_o == ST_FULL) |-> count_out_o == CAP_OUT)
  `CVL_ASSERT(a_count_bound, out_valid_o && (CAPACITY <= 256) |->
    ({1'b0, count_out_o} <= 10'(CAPACITY)))

endmodule

bind compacting_value_list_top cvl_checker #(
  .CAPACITY(CAPACITY)
) u_cvl_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .status_o       (status_o),
  .value_out_o    (value_out_o),
  .position_out_o (position_out_o),
  .count_out_o    (count_out_o)
);

[verif/testbench.sv]
// Self-checking testbench for compacting_value_list_top: directed and random list operations.
// Depends on cvl_pkg and the compacting_value_list_top RTL; it keeps its own copy of the list.
module testbench;
  import cvl_pkg::*;

  localparam int CAPACITY = CAPACITY_DEF;
  localparam int RANDOM_ITEMS = 1050;
  localparam int DIRECTED_ROWS = 23;
  localparam int TOTAL_BEATS = DIRECTED_ROWS + RANDOM_ITEMS;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam logic [OPCODE_W-1:0] OP_SPARE_LO = 3'd5;
  localparam logic [OPCODE_W-1:0] OP_SPARE_HI = 3'd7;

  typedef struct packed {
    status_e status;
    logic [VALUE_W-1:0] value;
    logic [POS_W-1:0] position;
    logic [COUNT_W-1:0] count;
  } list_answer_t;

  typedef struct packed {
    logic [OPCODE_W-1:0] op;
    logic [VALUE_W-1:0] value;
    logic [POS_W-1:0] position;
    logic typed;
    list_answer_t answer;
  } stim_row_t;

  // Rows marked typed carry their answer; the rest are checked against the list copy.
  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{OP_READ_IDX, 32'd0, 8'd0, 1'b1, '{ST_RANGE, 32'd0, 8'd0, 9'd0}},
    '{OP_REMOVE_IDX, 32'd0, 8'd255, 1'b1, '{ST_RANGE, 32'd0, 8'd0, 9'd0}},
    '{OP_FIND_VAL, 32'd0, 8'd0, 1'b1, '{ST_MISSING, 32'd0, 8'd0, 9'd0}},
    '{OP_REMOVE_VAL, 32'h8000_0000, 8'd0, 1'b1, '{ST_MISSING, 32'd0, 8'd0, 9'd0}},
    '{OP_SPARE_LO, 32'hffff_ffff, 8'd255, 1'b1, '{ST_OK, 32'd0, 8'd0, 9'd0}},
    '{OP_APPEND, 32'h7fff_ffff, 8'd255, 1'b1, '{ST_OK, 32'h7fff_ffff, 8'd0, 9'd1}},
    '{OP_APPEND, 32'h8000_0000, 8'd0, 1'b1, '{ST_OK, 32'h8000_0000, 8'd1, 9'd2}},
    '{OP_APPEND, 32'd0, 8'd0, 1'b1, '{ST_OK, 32'd0, 8'd2, 9'd3}},
    '{OP_APPEND, 32'h8000_0000, 8'd0, 1'b1, '{ST_OK, 32'h8000_0000, 8'd3, 9'd4}},
    '{OP_APPEND, 32'hffff_ffff, 8'd0, 1'b1, '{ST_OK, 32'hffff_ffff, 8'd4, 9'd5}},
    '{OP_FIND_VAL, 32'h8000_0000, 8'd0, 1'b0, '0},
    '{OP_READ_IDX, 32'd0, 8'd4, 1'b0, '0},
    '{OP_READ_IDX, 32'd0, 8'd5, 1'b1, '{ST_RANGE, 32'd0, 8'd0, 9'd5}},
    '{OP_READ_IDX, 32'd0, 8'd255, 1'b1, '{ST_RANGE, 32'd0, 8'd0, 9'd5}},
    '{OP_FIND_VAL, 32'd12345, 8'd0, 1'b1, '{ST_MISSING, 32'd0, 8'd0, 9'd5}},
    '{OP_REMOVE_VAL, 32'h8000_0000, 8'd0, 1'b0, '0},
    '{OP_FIND_VAL, 32'h8000_0000, 8'd0, 1'b0, '0},
    '{OP_REMOVE_IDX, 32'd0, 8'd0, 1'b0, '0},
    '{OP_REMOVE_IDX, 32'd0, 8'd2, 1'b0, '0},
    '{OP_REMOVE_IDX, 32'd0, 8'd2, 1'b0, '0},
    '{OP_SPARE_HI, 32'h5a5a_5a5a, 8'haa, 1'b0, '0},
    '{OP_READ_IDX, 32'd0, 8'd0, 1'b0, '0},
    '{OP_REMOVE_VAL, 32'hffff_ffff, 8'd0, 1'b0, '0}
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [OPCODE_W-1:0] opcode_i = '0;
  logic signed [VALUE_W-1:0] value_i = '0;
  logic [POS_W-1:0] position_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [STATUS_W-1:0] status_o;
  logic signed [VALUE_W-1:0] value_out_o;
  logic [POS_W-1:0] position_out_o;
  logic [COUNT_W-1:0] count_out_o;

  logic [VALUE_W-1:0] shadow_entries [CAPACITY];
  int shadow_count = 0;
  list_answer_t queued_answers [$];
  int mismatch_count = 0;
  int beats_sent = 0;
  int cycle_count = 0;
  int send_idle_pct = 12;
  int recv_idle_pct = 45;

  compacting_value_list_top i_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .opcode_i(opcode_i),
    .value_i(value_i),
    .position_i(position_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .status_o(status_o),
    .value_out_o(value_out_o),
    .position_out_o(position_out_o),
    .count_out_o(count_out_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic list_answer_t apply_list_op(input logic [OPCODE_W-1:0] op,
                                                 input logic [VALUE_W-1:0] val,
                                                 input logic [POS_W-1:0] pos);
    list_answer_t ans;
    int hit;
    int i;
    ans = '{ST_OK, 32'd0, 8'd0, 9'd0};
    hit = -1;
    case (op)
      OP_APPEND: begin
        if (shadow_count >= CAPACITY) begin
          ans.status = ST_FULL;
        end else begin
          shadow_entries[shadow_count] = val;
          ans.value = val;
          ans.position = shadow_count[POS_W-1:0];
          shadow_count++;
        end
      end
      OP_REMOVE_VAL, OP_FIND_VAL, OP_REMOVE_IDX, OP_READ_IDX: begin
        if (op == OP_REMOVE_VAL || op == OP_FIND_VAL) begin
          for (i = shadow_count - 1; i >= 0; i--) begin
            if (shadow_entries[i] == val) hit = i;
          end
          if (hit < 0) ans.status = ST_MISSING;
        end else begin
          if (int'(pos) < shadow_count) hit = int'(pos);
          else ans.status = ST_RANGE;
        end
        if (hit >= 0) begin
          ans.value = shadow_entries[hit];
          ans.position = hit[POS_W-1:0];
          if (op == OP_REMOVE_VAL || op == OP_REMOVE_IDX) begin
            for (i = hit; i < shadow_count - 1; i++) shadow_entries[i] = shadow_entries[i + 1];
            shadow_count--;
          end
        end
      end
      default: begin
      end
    endcase
    ans.count = shadow_count[COUNT_W-1:0];
    return ans;
  endfunction

  task automatic offer_beat(input logic [OPCODE_W-1:0] op, input logic [VALUE_W-1:0] val,
                            input logic [POS_W-1:0] pos, input logic typed,
                            input list_answer_t typed_answer);
    list_answer_t predicted;
    if (beats_sent < TOTAL_BEATS / 3) begin
      send_idle_pct = 12;
      recv_idle_pct = 45;
    end else if (beats_sent < 2 * TOTAL_BEATS / 3) begin
      send_idle_pct = 45;
      recv_idle_pct = 12;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    opcode_i <= op;
    value_i <= val;
    position_i <= pos;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = apply_list_op(op, val, pos);
    queued_answers.push_back(typed ? typed_answer : predicted);
    beats_sent++;
  endtask

  task automatic compare_field(input string name, input logic [VALUE_W-1:0] want,
                               input logic [VALUE_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (queued_answers.size() == 0) begin
        $display("%0t: result beat with nothing expected, actual status %0d value %h",
                 $time, status_o, value_out_o);
        mismatch_count++;
      end else begin
        compare_field("status", VALUE_W'(queued_answers[0].status), VALUE_W'(status_o));
        compare_field("value_out", queued_answers[0].value, value_out_o);
        compare_field("position_out", VALUE_W'(queued_answers[0].position),
                      VALUE_W'(position_out_o));
        compare_field("count_out", VALUE_W'(queued_answers[0].count), VALUE_W'(count_out_o));
        void'(queued_answers.pop_front());
      end
    end
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin : stimulus
    logic [OPCODE_W-1:0] op;
    logic [VALUE_W-1:0] val;
    logic [POS_W-1:0] pos;
    int roll;
    int n;
    bit draining;
    draining = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (n = 0; n < DIRECTED_ROWS; n++) begin
      offer_beat(DIRECTED[n].op, DIRECTED[n].value, DIRECTED[n].position,
                 DIRECTED[n].typed, DIRECTED[n].answer);
    end

    // The random part alternates between filling the list to capacity and draining it.
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (!draining && shadow_count == CAPACITY && $urandom_range(3) == 0) draining = 1'b1;
      if (draining && shadow_count == 0 && $urandom_range(3) == 0) draining = 1'b0;

      roll = $urandom_range(99);
      if (draining) begin
        if (roll < 35) op = OP_REMOVE_VAL;
        else if (roll < 70) op = OP_REMOVE_IDX;
        else if (roll < 80) op = OP_APPEND;
        else if (roll < 88) op = OP_FIND_VAL;
        else if (roll < 97) op = OP_READ_IDX;
        else op = OPCODE_W'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
      end else begin
        if (roll < 78) op = OP_APPEND;
        else if (roll < 84) op = OP_REMOVE_VAL;
        else if (roll < 88) op = OP_REMOVE_IDX;
        else if (roll < 93) op = OP_FIND_VAL;
        else if (roll < 98) op = OP_READ_IDX;
        else op = OPCODE_W'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
      end

      roll = $urandom_range(99);
      if (roll < 8) begin
        case ($urandom_range(3))
          0: val = 32'h8000_0000;
          1: val = 32'h7fff_ffff;
          2: val = 32'd0;
          default: val = 32'hffff_ffff;
        endcase
      end else if (roll < 30) begin
        val = $urandom_range(7);
      end else begin
        val = $urandom;
      end
      if ((op == OP_REMOVE_VAL || op == OP_FIND_VAL) && shadow_count > 0
          && $urandom_range(99) < 70) begin
        val = shadow_entries[$urandom_range(shadow_count - 1)];
      end

      roll = $urandom_range(99);
      if (shadow_count > 0 && roll < 70) pos = POS_W'($urandom_range(shadow_count - 1));
      else if (roll < 85) pos = shadow_count[POS_W-1:0];
      else pos = POS_W'($urandom_range(255));

      offer_beat(op, val, pos, 1'b0, '0);
    end
    in_valid_i <= 1'b0;

    while (queued_answers.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && queued_answers.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
